/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL of the sorted key table
// Concurrent checks on the rising clock edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SKTL_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sktl assertion failed");

// Antecedent implies consequent in the next cycle.
`define SKTL_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sktl assertion failed");

`endif

/* rtl/sktl_pkg.sv */
// ----------------------------------------------------------------------------
// sktl_pkg
// Field widths, input modes and controller states of the sorted key table.
// ----------------------------------------------------------------------------
package sktl_pkg;

	localparam int MODE_W  = 2;
	localparam int KEY_W   = 16;
	localparam int GRADE_W = 4;
	localparam int MARK_W  = 4;
	localparam int POS_W   = 3;
	localparam int TAG_W   = 3;

	localparam logic [MARK_W-1:0] PASS_MARK_RST = 4'd4;

	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR = 2'd0,
		MODE_LOAD  = 2'd1,
		MODE_QUERY = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEEK,
		ST_PROBE,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_INSERT,
		ST_RESULT
	} state_t;

endpackage

/* rtl/sktl_ram.sv */
// ----------------------------------------------------------------------------
// sktl_ram
// Table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sktl_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 19
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/sorted_key_table_lookup.sv */
// ----------------------------------------------------------------------------
// sorted_key_table_lookup
// Keeps distinct keys in ascending order in one table memory, each with its
// load-order tag, and answers graded queries by binary search.
// ----------------------------------------------------------------------------
//
//  Channel | Signals                                  | Dir | Notes
//  --------+------------------------------------------+-----+------------------
//  in      | in_valid, in_ready, mode, key, grade     | in  | one beat per item
//  out     | out_valid, out_ready, found,             | out | one beat per
//          | sorted_position, entry_tag               |     | answered query
//  cfg     | cfg_wen, cfg_wdata                       | in  | pass mark, no wait
//
// One item at a time: a new item is taken only once the last one is done.
// A clear, a dropped load (table full), a query below the pass mark or an
// unused mode goes straight back to idle. With stored keys a query seeks,
// then probes the table memory, one probe per cycle, then gives its result;
// a load searches, then moves the larger entries up to open its slot (one
// read, one write each) and inserts; a duplicate key ends after the search.
// On an empty table a query skips the search, and so does a load.
// Reset clears the entry count, the pass mark (to 4) and the output beat;
// the table memory is not cleared and needs no pass.
// The result waits in an output register: a stalled out channel holds the
// next answered query in its result step, and the input with it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_key_table_lookup #(
	parameter int DEPTH    = 8,
	parameter int KEY_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wen,
	input  logic [sktl_pkg::MARK_W-1:0]  cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [sktl_pkg::MODE_W-1:0]  mode,
	input  logic [sktl_pkg::KEY_W-1:0]   key,
	input  logic [sktl_pkg::GRADE_W-1:0] grade,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         found,
	output logic [sktl_pkg::POS_W-1:0]   sorted_position,
	output logic [sktl_pkg::TAG_W-1:0]   entry_tag
);

	import sktl_pkg::*;

	// Keys wider than the port carry only the port's bits.
	localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = KW + TAG_W;
	localparam int XW = CW + TAG_W;
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	// Control and search state
	state_t              state_q, state_d;
	logic                is_load_q;
	logic [KW-1:0]       key_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       lo_q, hi_q;
	logic [AW-1:0]       mid_q;
	logic                hit_q;
	logic [TAG_W-1:0]    hit_tag_q;
	logic [CW-1:0]       j_q;
	logic [MARK_W-1:0]   mark_q;

	// Output beat register
	logic                out_valid_q;
	logic                found_q;
	logic [POS_W-1:0]    pos_q;
	logic [TAG_W-1:0]    tag_q;

	// Table memory ports
	logic                rd_en, wr_en;
	logic [AW-1:0]       rd_addr, wr_addr;
	logic [EW-1:0]       rd_data, wr_data;

	// Search datapath
	logic [KW-1:0]       rd_key;
	logic [TAG_W-1:0]    rd_tag;
	logic                probe_lt, probe_eq, hit_new;
	logic [CW-1:0]       mid_c, nlo, nhi;
	logic [CW:0]         seek_sum, probe_sum;
	logic [CW-1:0]       seek_mid, probe_mid;
	logic [CW-1:0]       j_dec;
	logic [XW-1:0]       count_ext, lo_ext;
	logic                accept, out_free;

	sktl_ram #(
		.DEPTH (DEPTH),
		.WIDTH (EW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign rd_key = rd_data[EW-1:TAG_W];
	assign rd_tag = rd_data[TAG_W-1:0];

	// One probe step of the lower-bound search: the word read at mid_q
	// narrows [lo, hi) and picks the next probe address in the same cycle.
	assign mid_c     = CW'(mid_q);
	assign probe_lt  = rd_key < key_q;
	assign probe_eq  = rd_key == key_q;
	assign nlo       = probe_lt ? mid_c + 1'b1 : lo_q;
	assign nhi       = probe_lt ? hi_q : mid_c;
	// hi only moves onto a probed entry, so that probe tells whether the
	// final position holds the key.
	assign hit_new   = probe_lt ? hit_q : probe_eq;
	assign seek_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign seek_mid  = seek_sum[CW:1];
	assign probe_sum = {1'b0, nlo} + {1'b0, nhi};
	assign probe_mid = probe_sum[CW:1];
	assign j_dec     = j_q - 1'b1;
	assign count_ext = XW'(count_q);
	assign lo_ext    = XW'(lo_q);

	// Next state and memory control
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = seek_mid[AW-1:0];
		wr_en    = 1'b0;
		wr_addr  = lo_q[AW-1:0];
		wr_data  = {key_q, count_ext[TAG_W-1:0]};
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (mode)
						MODE_LOAD: begin
							if (count_q == FULL) begin
								state_d = ST_IDLE;
							end else if (count_q == '0) begin
								state_d = ST_SHIFT_RD;
							end else begin
								state_d = ST_SEEK;
							end
						end
						MODE_QUERY: begin
							if (grade < mark_q) begin
								state_d = ST_IDLE;
							end else if (count_q == '0) begin
								state_d = ST_RESULT;
							end else begin
								state_d = ST_SEEK;
							end
						end
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_SEEK: begin
				rd_en   = 1'b1;
				rd_addr = seek_mid[AW-1:0];
				state_d = ST_PROBE;
			end
			ST_PROBE: begin
				if (nlo < nhi) begin
					rd_en   = 1'b1;
					rd_addr = probe_mid[AW-1:0];
				end else if (!is_load_q) begin
					state_d = ST_RESULT;
				end else if (hit_new) begin
					// drop: key already present
					state_d = ST_IDLE;
				end else begin
					state_d = ST_SHIFT_RD;
				end
			end
			ST_SHIFT_RD: begin
				if (j_q > lo_q) begin
					rd_en   = 1'b1;
					rd_addr = j_dec[AW-1:0];
					state_d = ST_SHIFT_WR;
				end else begin
					state_d = ST_INSERT;
				end
			end
			ST_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_addr = j_q[AW-1:0];
				wr_data = rd_data;
				state_d = ST_SHIFT_RD;
			end
			ST_INSERT: begin
				wr_en   = 1'b1;
				wr_addr = lo_q[AW-1:0];
				wr_data = {key_q, count_ext[TAG_W-1:0]};
				state_d = ST_IDLE;
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= PASS_MARK_RST;
		end else if (cfg_wen) begin
			mark_q <= cfg_wdata;
		end
	end

	// Entry count: clear on a clear beat, advance on each insert.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && (mode == MODE_CLEAR)) begin
			count_q <= '0;
		end else if (state_q == ST_INSERT) begin
			count_q <= count_q + 1'b1;
		end
	end

	// Search and shift registers
	always_ff @(posedge clk) begin
		if (accept) begin
			is_load_q <= (mode == MODE_LOAD);
			key_q     <= key[KW-1:0];
			lo_q      <= '0;
			hi_q      <= count_q;
			hit_q     <= 1'b0;
			j_q       <= count_q;
		end
		if (state_q == ST_SEEK) begin
			mid_q <= seek_mid[AW-1:0];
		end
		if (state_q == ST_PROBE) begin
			lo_q  <= nlo;
			hi_q  <= nhi;
			mid_q <= probe_mid[AW-1:0];
			if (!probe_lt) begin
				hit_q     <= probe_eq;
				hit_tag_q <= rd_tag;
			end
		end
		if (state_q == ST_SHIFT_WR) begin
			j_q <= j_dec;
		end
	end

	// Output beat: load when the slot is free, drop on a taken beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_RESULT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_RESULT) && out_free) begin
			found_q <= hit_q;
			pos_q   <= hit_q ? lo_ext[POS_W-1:0] : '0;
			tag_q   <= hit_q ? hit_tag_q : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign found           = found_q;
	assign sorted_position = pos_q;
	assign entry_tag       = tag_q;

	`SKTL_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL)
	`SKTL_ASSERT_IMPL(a_probe_range, clk, arst_n, state_q == ST_PROBE, lo_q < hi_q)
	`SKTL_ASSERT_IMPL(a_shift_range, clk, arst_n, state_q == ST_SHIFT_WR, (j_q > lo_q) && (j_q <= count_q))
	`SKTL_ASSERT_NEXT(a_clear_empties, clk, arst_n, accept && (mode == MODE_CLEAR), count_q == '0)
	`SKTL_ASSERT_NEXT(a_insert_grows, clk, arst_n, state_q == ST_INSERT, count_q == $past(count_q) + 1'b1)

endmodule

/* test/sorted_key_table_lookup_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_table_lookup_tb
// Drives clear, load and graded query beats into the sorted key table and
// checks every answered lookup against a predictor kept in step with the
// accepted input beats. Directed table cases come first, then random
// load/query rounds under three idling patterns and one long output stall.
// ----------------------------------------------------------------------------
module sorted_key_table_lookup_tb;
	import sktl_pkg::*;

	localparam int TABLE_DEPTH  = 8;
	localparam int DRAIN_CYCLES = 48;     // longest load: search plus 7 moves
	localparam int CYCLE_LIMIT  = 400000;
	localparam int STALL_CYCLES = 300;

	// One answered lookup as it leaves the block.
	typedef struct packed {
		logic             hit;
		logic [POS_W-1:0] pos;
		logic [TAG_W-1:0] tag;
	} lookup_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_wen;
	logic [MARK_W-1:0]   cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	logic [MODE_W-1:0]   mode;
	logic [KEY_W-1:0]    key;
	logic [GRADE_W-1:0]  grade;
	logic                out_valid;
	logic                out_ready;
	logic                found;
	logic [POS_W-1:0]    sorted_position;
	logic [TAG_W-1:0]    entry_tag;

	// Predictor state: sorted keys, their load-order tags, fill level, mark.
	logic [KEY_W-1:0]    stored_keys [TABLE_DEPTH];
	logic [TAG_W-1:0]    stored_tags [TABLE_DEPTH];
	int                  key_count;
	logic [MARK_W-1:0]   pass_mark_cfg;

	lookup_t             lookup_q [$];
	lookup_t             want;

	// Idle rates in percent, stall request for the receiver, bookkeeping.
	int                  tx_idle_pct;
	int                  rx_idle_pct;
	int                  stall_req;
	int                  stall_left;
	int                  items_sent;
	int                  lookups_seen;
	int                  hits_seen;
	int                  loads_dropped;
	int                  queries_below_mark;
	int                  errors;
	int                  cycle_cnt;

	sorted_key_table_lookup uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.key             (key),
		.grade           (grade),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.found           (found),
		.sorted_position (sorted_position),
		.entry_tag       (entry_tag)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: a hung handshake must not run forever.
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("%0t: timeout after %0d cycles, %0d lookups still pending",
			$time, cycle_cnt, lookup_q.size());
		$display("FAILURE");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	// Number of stored keys strictly below k, found by halving the range.
	function automatic int count_below(input logic [KEY_W-1:0] k);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = key_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (stored_keys[mid] < k)
				lo = mid + 1;
			else
				hi = mid;
		end
		return lo;
	endfunction

	// Advance the predictor by one accepted beat; queue the lookup it answers.
	function automatic void predict_item(input mode_t m, input logic [KEY_W-1:0] k,
			input logic [GRADE_W-1:0] g);
		int      pos;
		lookup_t res;
		case (m)
			MODE_CLEAR: begin
				// Only the fill level drops; stale entries are never read again.
				key_count = 0;
			end
			MODE_LOAD: begin
				pos = count_below(k);
				if (key_count >= TABLE_DEPTH || (pos < key_count && stored_keys[pos] == k)) begin
					loads_dropped++;
				end else begin
					// Open the slot by moving the larger keys up one place.
					for (int i = key_count; i > pos; i--) begin
						stored_keys[i] = stored_keys[i-1];
						stored_tags[i] = stored_tags[i-1];
					end
					stored_keys[pos] = k;
					stored_tags[pos] = TAG_W'(key_count);
					key_count++;
				end
			end
			MODE_QUERY: begin
				if (g < pass_mark_cfg) begin
					queries_below_mark++;
				end else begin
					pos = count_below(k);
					if (pos < key_count && stored_keys[pos] == k) begin
						res.hit = 1'b1;
						res.pos = POS_W'(pos);
						res.tag = stored_tags[pos];
					end else begin
						res = '0;
					end
					lookup_q.push_back(res);
				end
			end
			default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Receiver: random ready, plus a long hold-off when a test asks for one.
	// ------------------------------------------------------------------------
	initial begin
		out_ready <= 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (stall_req > 0) begin
				stall_left = stall_req - 1;
				stall_req  = 0;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result checker: every output beat against the oldest expected lookup.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (lookup_q.size() == 0) begin
				$display("%0t: unexpected lookup beat: found=%0d pos=%0d tag=%0d",
					$time, found, sorted_position, entry_tag);
				errors++;
			end else begin
				want = lookup_q.pop_front();
				lookups_seen++;
				if (want.hit)
					hits_seen++;
				if (found !== want.hit) begin
					$display("%0t: found mismatch: expected %0d, got %0d",
						$time, want.hit, found);
					errors++;
				end
				if (sorted_position !== want.pos) begin
					$display("%0t: sorted_position mismatch: expected %0d, got %0d",
						$time, want.pos, sorted_position);
					errors++;
				end
				if (entry_tag !== want.tag) begin
					$display("%0t: entry_tag mismatch: expected %0d, got %0d",
						$time, want.tag, entry_tag);
					errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Shared drivers
	// ------------------------------------------------------------------------

	// Offer one beat, after a random gap, and hold it until accepted.
	// Valid stays high on return so back-to-back beats need no extra edge.
	task automatic send_item(input mode_t m, input logic [KEY_W-1:0] k,
			input logic [GRADE_W-1:0] g);
		int gap;
		gap = 0;
		if ($urandom_range(99, 0) < tx_idle_pct)
			gap = $urandom_range(4, 1);
		if (gap > 0) begin
			// Scramble the payload while valid is low; the block must ignore it.
			in_valid <= 1'b0;
			mode     <= MODE_W'($urandom_range(3, 0));
			key      <= KEY_W'($urandom_range(65535, 0));
			grade    <= GRADE_W'($urandom_range(15, 0));
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode     <= m;
		key      <= k;
		grade    <= g;
		do @(posedge clk); while (!in_ready);
		predict_item(m, k, g);
		if (m != MODE_NONE)
			items_sent++;
	endtask

	// Drop valid, let every expected lookup drain, then let the block settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (lookup_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write the pass mark only once the block has gone quiet.
	task automatic write_pass_mark(input logic [MARK_W-1:0] v);
		wait_idle();
		cfg_wen   <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		pass_mark_cfg = v;
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Extremes of the key range, duplicate and full-table loads, unused mode,
	// grade right at and just below the reset pass mark, clear with stale data.
	task automatic test_directed_table();
		send_item(MODE_CLEAR, 16'h0000, 4'd0);
		send_item(MODE_QUERY, 16'h1234, 4'd15);   // empty table
		send_item(MODE_LOAD,  16'hFFFF, 4'd0);
		send_item(MODE_LOAD,  16'h0000, 4'd15);
		send_item(MODE_LOAD,  16'h8000, 4'd7);
		send_item(MODE_LOAD,  16'h0000, 4'd0);    // duplicate, dropped
		send_item(MODE_LOAD,  16'h7FFF, 4'd0);
		send_item(MODE_LOAD,  16'h5555, 4'd0);
		send_item(MODE_LOAD,  16'hAAAA, 4'd0);
		send_item(MODE_LOAD,  16'h0001, 4'd0);
		send_item(MODE_LOAD,  16'hFFFE, 4'd0);    // table now full
		send_item(MODE_LOAD,  16'h1234, 4'd0);    // full, dropped
		send_item(MODE_QUERY, 16'h0000, 4'd15);
		send_item(MODE_QUERY, 16'hFFFF, 4'd4);    // grade equals pass mark
		send_item(MODE_QUERY, 16'h7FFF, 4'd9);
		send_item(MODE_QUERY, 16'h1234, 4'd15);   // missing key
		send_item(MODE_QUERY, 16'hFFFF, 4'd3);    // below pass mark
		send_item(MODE_QUERY, 16'h8000, 4'd0);    // below pass mark
		send_item(MODE_NONE,  16'hFFFF, 4'd15);   // unused mode
		send_item(MODE_CLEAR, 16'hFFFF, 4'd15);
		send_item(MODE_QUERY, 16'hFFFF, 4'd15);   // stale entry, not found
		send_item(MODE_QUERY, 16'h0000, 4'd15);
	endtask

	// Pass mark at both ends: only grade 15 passes, then every grade passes.
	task automatic test_pass_mark_extremes();
		write_pass_mark(4'd15);
		send_item(MODE_LOAD,  16'h4321, 4'd0);
		send_item(MODE_QUERY, 16'h4321, 4'd14);
		send_item(MODE_QUERY, 16'h4321, 4'd15);
		write_pass_mark(4'd0);
		send_item(MODE_QUERY, 16'h4321, 4'd0);
		send_item(MODE_QUERY, 16'h4320, 4'd0);
	endtask

	// Rounds of clear, loads, then mostly hitting queries with random content.
	task automatic test_random_traffic(input int n_items);
		int               target;
		int               n_load;
		int               n_query;
		int               pick;
		bit               narrow;
		logic [KEY_W-1:0] base;
		logic [KEY_W-1:0] k;
		logic [GRADE_W-1:0] g;
		logic [KEY_W-1:0] loaded [$];
		target = items_sent + n_items;
		while (items_sent < target) begin
			// Most rounds start from an empty table; some build on the last one.
			if ($urandom_range(9, 0) != 0) begin
				send_item(MODE_CLEAR, KEY_W'($urandom_range(65535, 0)),
					GRADE_W'($urandom_range(15, 0)));
				loaded.delete();
			end
			// Narrow key windows force duplicates; wide ones cover every bit.
			narrow = ($urandom_range(3, 0) == 0);
			base   = KEY_W'($urandom_range(65535, 0));
			n_load = $urandom_range(10, 1);
			for (int i = 0; i < n_load; i++) begin
				k = narrow ? base + KEY_W'($urandom_range(11, 0))
					: KEY_W'($urandom_range(65535, 0));
				loaded.push_back(k);
				send_item(MODE_LOAD, k, GRADE_W'($urandom_range(15, 0)));
			end
			n_query = $urandom_range(12, 3);
			for (int i = 0; i < n_query; i++) begin
				pick = $urandom_range(99, 0);
				k    = loaded[$urandom_range(loaded.size() - 1, 0)];
				if (pick >= 80)
					k = KEY_W'($urandom_range(65535, 0));
				else if (pick >= 60)
					k = ($urandom_range(1, 0) != 0) ? k + 1'b1 : k - 1'b1;
				if ($urandom_range(99, 0) < 80)
					g = GRADE_W'($urandom_range(15, pass_mark_cfg));
				else
					g = GRADE_W'($urandom_range(15, 0));
				send_item(MODE_QUERY, k, g);
			end
			// Occasional noise: an unused mode or a fully random beat.
			if ($urandom_range(19, 0) == 0)
				send_item(MODE_NONE, KEY_W'($urandom_range(65535, 0)),
					GRADE_W'($urandom_range(15, 0)));
			if ($urandom_range(19, 0) == 0)
				send_item(mode_t'($urandom_range(3, 0)), KEY_W'($urandom_range(65535, 0)),
					GRADE_W'($urandom_range(15, 0)));
		end
	endtask

	// Hold the output off for a long stretch while queries keep coming, so
	// the result register fills and the block stops taking input beats.
	task automatic test_output_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		stall_req   = STALL_CYCLES;
		send_item(MODE_CLEAR, 16'h0000, 4'd0);
		for (int i = 0; i < 4; i++)
			send_item(MODE_LOAD, KEY_W'(16'h1000 * i + 16'h0100), 4'd0);
		for (int i = 0; i < 16; i++)
			send_item(MODE_QUERY, KEY_W'(16'h1000 * (i % 5) + 16'h0100), 4'd15);
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		// Known values on every input from time zero.
		arst_n    <= 1'b0;
		cfg_wen   <= 1'b0;
		cfg_wdata <= '0;
		in_valid  <= 1'b0;
		mode      <= MODE_CLEAR;
		key       <= '0;
		grade     <= '0;
		tx_idle_pct = 18;
		rx_idle_pct = 60;
		stall_req   = 0;
		items_sent  = 0;
		lookups_seen = 0;
		hits_seen   = 0;
		loads_dropped = 0;
		queries_below_mark = 0;
		errors      = 0;
		key_count   = 0;
		pass_mark_cfg = PASS_MARK_RST;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			stored_keys[i] = '0;
			stored_tags[i] = '0;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_table();
		test_pass_mark_extremes();

		write_pass_mark(MARK_W'($urandom_range(7, 1)));
		test_random_traffic(600);

		tx_idle_pct = 60;
		rx_idle_pct = 18;
		write_pass_mark(MARK_W'($urandom_range(14, 8)));
		test_random_traffic(600);

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_pass_mark(PASS_MARK_RST);
		test_random_traffic(600);

		test_output_backpressure();

		wait_idle();

		$display("Run covered %0d beats: %0d lookups answered, %0d of them hits.",
			items_sent, lookups_seen, hits_seen);
		$display("Loads dropped as full or duplicate: %0d; queries under the mark: %0d.",
			loads_dropped, queries_below_mark);
		if (errors == 0 && lookup_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches, %0d lookups never arrived", errors, lookup_q.size());
			$display("FAILURE");
		end
		$finish;
	end

endmodule
